// ----- src/tccs_pkg.sv -----
// Package for the text console: character codes, operation codes, default
// screen size and the command/status structs between controller and datapath.
// No dependencies.
package tccs_pkg;

  localparam int ColumnsDefault = 32;
  localparam int RowsDefault    = 16;

  // Operation codes of an input item
  localparam logic [1:0] OpPut   = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // Character codes with a special meaning
  localparam logic [7:0] CodeClear = 8'd147;
  localparam logic [7:0] CodeCase  = 8'd14;
  localparam logic [7:0] CodeLf    = 8'd10;
  localparam logic [7:0] CodeCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;

  typedef struct packed {
    logic accept;        // apply the current input item
    logic sweep_run;     // issue one sweep cell this cycle
    logic sweep_copy;    // sweep moves rows up instead of only blanking
    logic out_load;      // load the result register
    logic out_from_read; // result carries the registered read data
  } tccs_cmd_t;

  typedef struct packed {
    logic item_clear;    // current item clears the screen
    logic item_scroll;   // current item scrolls the screen
    logic item_read;     // current item reads a cell
    logic sweep_last;    // sweep is at its last cell
    logic out_busy;      // result register holds an item that is stalled
  } tccs_status_t;

endpackage

// ----- src/tccs_ctrl.sv -----
// Controller of the text console: sequences accept, cell reads and the
// clear/scroll sweeps over the screen store. Uses tccs_pkg.
module tccs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tccs_pkg::tccs_status_t status_i,
  output tccs_pkg::tccs_cmd_t    cmd_o
);
  import tccs_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StSweep,
    StDrain
  } state_e;

  state_e state_q, state_d;
  logic   copy_q, copy_d;
  logic   report_q, report_d;

  assign in_stall_o = (state_q != StIdle) || status_i.out_busy;

  always_comb begin
    state_d  = state_q;
    copy_d   = copy_q;
    report_d = report_q;
    cmd_o    = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.accept = 1'b1;
          if (status_i.item_clear) begin
            state_d  = StSweep;
            copy_d   = 1'b0;
            report_d = 1'b1;
          end else if (status_i.item_scroll) begin
            state_d  = StSweep;
            copy_d   = 1'b1;
            report_d = 1'b1;
          end else if (status_i.item_read) begin
            state_d = StRead;
          end else begin
            cmd_o.out_load = 1'b1;
          end
        end
      end
      StRead: begin
        cmd_o.out_load      = 1'b1;
        cmd_o.out_from_read = 1'b1;
        state_d             = StIdle;
      end
      StSweep: begin
        cmd_o.sweep_run  = 1'b1;
        cmd_o.sweep_copy = copy_q;
        if (status_i.sweep_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last sweep write lands this cycle
        cmd_o.out_load = report_q;
        state_d        = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StSweep;
      copy_q   <= 1'b0;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      copy_q   <= copy_d;
      report_q <= report_d;
    end
  end

endmodule

// ----- src/tccs_dp.sv -----
// Datapath of the text console: screen store, cursor, case flag, sweep
// counter and result register. Uses tccs_pkg.
module tccs_dp #(
  parameter int COLUMNS = tccs_pkg::ColumnsDefault,
  parameter int ROWS    = tccs_pkg::RowsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tccs_pkg::tccs_cmd_t    cmd_i,
  output tccs_pkg::tccs_status_t status_o,
  input  logic [1:0]             operation_i,
  input  logic [7:0]             data_byte_i,
  input  logic [8:0]             cell_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             read_data_o,
  output logic [4:0]             cursor_col_o,
  output logic [3:0]             cursor_row_o,
  output logic                   upper_case_o
);
  import tccs_pkg::*;

  localparam int Cells = COLUMNS * ROWS;
  localparam int AW    = $clog2(Cells);
  localparam int XW    = $clog2(COLUMNS);
  localparam int YW    = $clog2(ROWS);

  logic [7:0]    mem_q [Cells];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [XW-1:0] cursor_x_q, cursor_x_d;
  logic [YW-1:0] cursor_y_q, cursor_y_d;
  logic          case_q, case_d;

  logic [AW-1:0] cnt_q, cnt_d;
  logic          pend_valid_q;
  logic [AW-1:0] pend_addr_q;
  logic          pend_copy_q;
  logic          rd_ok_q;

  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic [4:0]    out_col_q;
  logic [3:0]    out_row_q;
  logic          out_case_q;

  logic          is_put, is_clr, is_case, is_nl, is_plain;
  logic          x_last, y_last, row_adv, idx_ok, cnt_copy;
  logic [AW-1:0] cur_addr;

  always_comb begin
    is_put   = (operation_i == OpPut);
    is_clr   = is_put && (data_byte_i == CodeClear);
    is_case  = is_put && (data_byte_i == CodeCase);
    is_nl    = is_put && ((data_byte_i == CodeLf) || (data_byte_i == CodeCr));
    is_plain = is_put && !is_clr && !is_case && !is_nl;
    x_last   = (cursor_x_q == XW'(COLUMNS - 1));
    y_last   = (cursor_y_q == YW'(ROWS - 1));
    row_adv  = is_nl || (is_plain && x_last);
    idx_ok   = (32'(cell_index_i) < Cells);
    cur_addr = AW'(32'(cursor_y_q) * COLUMNS + 32'(cursor_x_q));
    cnt_copy = (32'(cnt_q) < Cells - COLUMNS);

    status_o.item_clear  = is_clr;
    status_o.item_scroll = row_adv && y_last;
    status_o.item_read   = (operation_i == OpRead);
    status_o.sweep_last  = (cnt_q == AW'(Cells - 1));
    status_o.out_busy    = out_valid_q && out_stall_i;
  end

  // Store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = data_byte_i;
    if (pend_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_copy_q ? rdata_q : CharSpace;
    end else if (cmd_i.accept && (operation_i == OpWrite) && idx_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cell_index_i);
    end else if (cmd_i.accept && is_plain) begin
      mem_we = 1'b1;
    end
    mem_raddr = cmd_i.sweep_run ? (cnt_q + AW'(COLUMNS)) : AW'(cell_index_i);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Cursor and case flag
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    case_d     = case_q;
    if (cmd_i.accept) begin
      if (is_clr) begin
        cursor_x_d = '0;
        cursor_y_d = '0;
      end else if (is_case) begin
        case_d = !case_q;
      end else if (is_nl || is_plain) begin
        if (is_plain) begin
          cursor_x_d = x_last ? '0 : cursor_x_q + 1'b1;
        end else if (data_byte_i == CodeCr) begin
          cursor_x_d = '0;
        end
        // bottom row: hold the row, the sweep scrolls the screen
        if (row_adv && !y_last) begin
          cursor_y_d = cursor_y_q + 1'b1;
        end
      end
    end
  end

  assign cnt_d = cmd_i.sweep_run ? cnt_q + 1'b1 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      case_q       <= 1'b1;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cursor_x_q   <= cursor_x_d;
      cursor_y_q   <= cursor_y_d;
      case_q       <= case_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= cmd_i.sweep_run;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= cnt_q;
    pend_copy_q <= cmd_i.sweep_copy && cnt_copy;
    if (cmd_i.accept) begin
      rd_ok_q <= idx_ok;
    end
    if (cmd_i.out_load) begin
      out_data_q <= (cmd_i.out_from_read && rd_ok_q) ? rdata_q : 8'd0;
      out_col_q  <= 5'(cursor_x_d);
      out_row_q  <= 4'(cursor_y_d);
      out_case_q <= case_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign upper_case_o = out_case_q;

endmodule

// ----- src/text_console_cursor_scroll.sv -----
// Text console with cursor, wrap and scroll: top level joining the
// controller and the datapath. Uses tccs_pkg, tccs_ctrl and tccs_dp.
//
// Input channel (in_valid_i / in_stall_o) carries one operation per item:
// put a character at the cursor, write one cell, or read one cell. The
// output channel (out_valid_o / out_stall_i) returns one result per item:
// read data (zero unless a read), the cursor after the operation and the
// case flag. Items are taken one at a time.
// A read result passes through the registered store read. A clear code
// or a put that moves below the last row runs a sweep over the whole
// store, one cell per cycle through the single store port pair.
// After reset the store is blanked to spaces by the same sweep; no item
// is accepted meanwhile and no result is produced for it.
// The result sits in an output register; a new item is accepted while
// that register is empty or being taken. When the receiver stalls, the
// result holds and the input stalls until it is taken.
module text_console_cursor_scroll #(
  parameter int COLUMNS = tccs_pkg::ColumnsDefault,
  parameter int ROWS    = tccs_pkg::RowsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [8:0] cell_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [4:0] cursor_col_o,
  output logic [3:0] cursor_row_o,
  output logic       upper_case_o
);
  import tccs_pkg::*;

  tccs_cmd_t    cmd;
  tccs_status_t status;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .operation_i  (operation_i),
    .data_byte_i  (data_byte_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .upper_case_o (upper_case_o)
  );

endmodule

// ----- dv/text_console_cursor_scroll_tb.sv -----
// Self-checking testbench for text_console_cursor_scroll: a table of directed items,
// then random items; each result is checked against the table or a model of the console.
// Depends on tccs_pkg and the console RTL.
module text_console_cursor_scroll_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccs_pkg::*;

  localparam int Columns   = ColumnsDefault;
  localparam int Rows      = RowsDefault;
  localparam int Cells     = Columns * Rows;
  localparam int RandItems = 1200;
  localparam int DirCount  = 20;
  localparam int SweepWait = Cells + 8;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] cursor_col;
    logic [3:0] cursor_row;
    logic       upper_case;
  } console_result_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [7:0]      data;
    logic [8:0]      index;
    logic            fixed;
    console_result_t result;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic [8:0] cell_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_data;
  logic [4:0] cursor_col;
  logic [3:0] cursor_row;
  logic       upper_case;

  text_console_cursor_scroll dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .data_byte_i (data_byte),
    .cell_index_i(cell_index),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_data_o (read_data),
    .cursor_col_o(cursor_col),
    .cursor_row_o(cursor_row),
    .upper_case_o(upper_case)
  );

  // Console model state
  logic [7:0] screen_model [Cells];
  int         model_x;
  int         model_y;
  logic       model_upper;

  console_result_t pending_results [$];
  int errors;
  int num_puts, num_writes, num_reads, num_scrolls, num_clears, num_wraps;
  int burst_left;

  stim_row_t dir_table [DirCount] = '{
    '{OpRead,   8'd0,      9'd0,   1'b1, '{8'd32,  5'd0, 4'd0, 1'b1}},
    '{OpRead,   8'd0,      9'd511, 1'b1, '{8'd32,  5'd0, 4'd0, 1'b1}},
    '{OpUnused, 8'd255,    9'd511, 1'b1, '{8'd0,   5'd0, 4'd0, 1'b1}},
    '{OpPut,    CodeCase,  9'd0,   1'b1, '{8'd0,   5'd0, 4'd0, 1'b0}},
    '{OpPut,    CodeCase,  9'd0,   1'b1, '{8'd0,   5'd0, 4'd0, 1'b1}},
    '{OpPut,    8'd65,     9'd0,   1'b1, '{8'd0,   5'd1, 4'd0, 1'b1}},
    '{OpRead,   8'd0,      9'd0,   1'b1, '{8'd65,  5'd1, 4'd0, 1'b1}},
    '{OpWrite,  8'd255,    9'd511, 1'b1, '{8'd0,   5'd1, 4'd0, 1'b1}},
    '{OpRead,   8'd0,      9'd511, 1'b1, '{8'd255, 5'd1, 4'd0, 1'b1}},
    '{OpPut,    CodeLf,    9'd0,   1'b1, '{8'd0,   5'd1, 4'd1, 1'b1}},
    '{OpPut,    CodeCr,    9'd0,   1'b1, '{8'd0,   5'd0, 4'd2, 1'b1}},
    '{OpPut,    8'd0,      9'd0,   1'b1, '{8'd0,   5'd1, 4'd2, 1'b1}},
    '{OpRead,   8'd0,      9'd64,  1'b1, '{8'd0,   5'd1, 4'd2, 1'b1}},
    '{OpPut,    8'd255,    9'd0,   1'b0, '0},
    '{OpWrite,  8'd0,      9'd0,   1'b0, '0},
    '{OpPut,    CodeClear, 9'd0,   1'b1, '{8'd0,   5'd0, 4'd0, 1'b1}},
    '{OpRead,   8'd0,      9'd511, 1'b1, '{8'd32,  5'd0, 4'd0, 1'b1}},
    '{OpRead,   8'd0,      9'd64,  1'b1, '{8'd32,  5'd0, 4'd0, 1'b1}},
    '{OpWrite,  8'd66,     9'd480, 1'b0, '0},
    '{OpRead,   8'd0,      9'd480, 1'b0, '0}
  };

  function automatic void scroll_model();
    for (int i = 0; i < (Rows - 1) * Columns; i++) screen_model[i] = screen_model[i + Columns];
    for (int i = (Rows - 1) * Columns; i < Cells; i++) screen_model[i] = CharSpace;
    num_scrolls++;
  endfunction

  function automatic void put_model(logic [7:0] code);
    case (code)
      CodeClear: begin
        for (int i = 0; i < Cells; i++) screen_model[i] = CharSpace;
        model_x = 0;
        model_y = 0;
        num_clears++;
      end
      CodeCase: model_upper = ~model_upper;
      CodeLf:   model_y++;
      CodeCr: begin
        model_y++;
        model_x = 0;
      end
      default: begin
        if (model_x < Columns && model_y < Rows) screen_model[model_y * Columns + model_x] = code;
        model_x++;
      end
    endcase
    if (model_x >= Columns) begin
      model_x = 0;
      model_y++;
      num_wraps++;
    end
    if (model_y > Rows - 1) begin
      model_y = Rows - 1;
      scroll_model();
    end
  endfunction

  function automatic console_result_t console_step(logic [1:0] op, logic [7:0] data,
                                                   logic [8:0] index);
    console_result_t res;
    res = '0;
    case (op)
      OpPut: begin
        put_model(data);
        num_puts++;
      end
      OpWrite: begin
        if (index < Cells) screen_model[index] = data;
        num_writes++;
      end
      OpRead: begin
        if (index < Cells) res.read_data = screen_model[index];
        num_reads++;
      end
      default: ;
    endcase
    res.cursor_col = model_x[4:0];
    res.cursor_row = model_y[3:0];
    res.upper_case = model_upper;
    return res;
  endfunction

  // Present one item, hold it until taken, then record what it should return.
  task automatic send_item(logic [1:0] op, logic [7:0] data, logic [8:0] index, logic fixed,
                           console_result_t typed);
    console_result_t res;
    @(negedge clk);
    in_valid   <= 1'b1;
    operation  <= op;
    data_byte  <= data;
    cell_index <= index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = console_step(op, data, index);
    pending_results.push_back(fixed ? typed : res);
  endtask

  // Bursts of back-to-back items separated by random gaps.
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern: random picks among four stall modes.
  initial begin
    int mode;
    int count;
    out_stall = 1'b0;
    mode      = 0;
    count     = 0;
    forever begin
      @(negedge clk);
      count++;
      if (count % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (count % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: rd=%0d col=%0d row=%0d uc=%0d",
                 $time, read_data, cursor_col, cursor_row, upper_case);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.read_data) begin
          $display("%0t: read_data expected %0d actual %0d", $time, want.read_data, read_data);
          errors++;
        end
        if (cursor_col !== want.cursor_col) begin
          $display("%0t: cursor_col expected %0d actual %0d", $time, want.cursor_col,
                   cursor_col);
          errors++;
        end
        if (cursor_row !== want.cursor_row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time, want.cursor_row,
                   cursor_row);
          errors++;
        end
        if (upper_case !== want.upper_case) begin
          $display("%0t: upper_case expected %0d actual %0d", $time, want.upper_case,
                   upper_case);
          errors++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("text_console_cursor_scroll_tb failed");
    $finish;
  end

  initial begin
    int          pick;
    int          line_left;
    logic [1:0]  op;
    logic [7:0]  data;
    logic [8:0]  index;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    operation  = OpPut;
    data_byte  = '0;
    cell_index = '0;
    errors     = 0;
    burst_left = 0;
    line_left  = 0;
    num_puts = 0; num_writes = 0; num_reads = 0;
    num_scrolls = 0; num_clears = 0; num_wraps = 0;
    for (int i = 0; i < Cells; i++) screen_model[i] = CharSpace;
    model_x     = 0;
    model_y     = 0;
    model_upper = 1'b1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      send_item(dir_table[i].op, dir_table[i].data, dir_table[i].index, dir_table[i].fixed,
                dir_table[i].result);
      sender_gap();
    end
    drain_results();

    for (int n = 0; n < RandItems; n++) begin
      index = 9'($urandom_range(0, Cells - 1));
      data  = 8'($urandom_range(0, 255));
      op    = OpPut;
      if (line_left > 0) begin
        // Text run that can wrap the cursor.
        data = 8'($urandom_range(32, 126));
        line_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          line_left = $urandom_range(20, 70);
          data = 8'($urandom_range(32, 126));
        end else if (pick < 40) begin
          data = 8'($urandom_range(32, 126));
        end else if (pick < 48) begin
          // any code
        end else if (pick < 56) begin
          data = CodeCr;
        end else if (pick < 62) begin
          data = CodeLf;
        end else if (pick < 64) begin
          data = CodeCase;
        end else if (pick < 65) begin
          data = CodeClear;
        end else if (pick < 80) begin
          op = OpWrite;
        end else if (pick < 96) begin
          op = OpRead;
        end else begin
          op = OpUnused;
        end
      end
      send_item(op, data, index, 1'b0, '0);
      if (n == RandItems / 2) drain_results();
      else sender_gap();
    end

    drain_results();
    repeat (SweepWait) @(posedge clk);
    $display("Covered %0d puts, %0d writes, %0d reads, %0d scrolls, %0d clears, %0d wraps;",
             num_puts, num_writes, num_reads, num_scrolls, num_clears, num_wraps);
    $display("%0d mismatches seen.", errors);
    if (errors == 0) begin
      $display("text_console_cursor_scroll_tb passed");
    end else begin
      $display("text_console_cursor_scroll_tb failed");
    end
    $finish;
  end

endmodule
